FILE: design/atsl_pkg.sv
// ----------------------------------------------------------------------------
// atsl_pkg
// shared types and codes of the address to symbol lookup block
// ----------------------------------------------------------------------------
package atsl_pkg;

  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned COUNT_W = 9;

  localparam logic [1:0] ACT_LOAD_REGION = 2'd0;
  localparam logic [1:0] ACT_LOAD_SYMBOL = 2'd1;
  localparam logic [1:0] ACT_QUERY       = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic [3:0]         region_slot;
    logic [7:0]         symbol_slot;
    logic [ADDR_W-1:0]  start_value;
    logic [ADDR_W-1:0]  span;
    logic [ADDR_W-1:0]  reloc_bias;
    logic [COUNT_W-1:0] symbol_total;
    logic               in_use;
    logic               defined;
    logic               named;
    logic               thread_local;
  } in_beat_t;

  typedef struct packed {
    logic              found_object;
    logic [3:0]        object_index;
    logic [ADDR_W-1:0] object_base;
    logic              found_symbol;
    logic [7:0]        symbol_index;
    logic [ADDR_W-1:0] symbol_address;
  } out_beat_t;

  // region entry keeps the end address so the query needs compares only
  typedef struct packed {
    logic [ADDR_W-1:0]  base;
    logic [ADDR_W-1:0]  fin;
    logic [ADDR_W-1:0]  bias;
    logic [COUNT_W-1:0] count;
    logic               live;
  } region_entry_t;

  typedef struct packed {
    logic defined;
    logic named;
    logic tls;
  } sym_flags_t;

  typedef struct packed {
    logic [ADDR_W-1:0] value;
    logic [ADDR_W-1:0] size;
    sym_flags_t        flags;
  } sym_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RSCAN,
    ST_SSCAN,
    ST_DONE
  } state_t;

endpackage

FILE: design/address_to_symbol_lookup.sv
// ----------------------------------------------------------------------------
// address_to_symbol_lookup
// region table and per-region symbol store with nearest symbol query
// ----------------------------------------------------------------------------
//  channel | ports                          | beat taken when
//  --------+--------------------------------+-------------------------------
//  input   | start, busy, in_data           | start high and busy low
//  result  | out_valid, out_data            | every cycle out_valid is high
//
//  loads give no result; busy stays low.
//  a query holds busy for a region scan up to the containing region (to the
//  last region when none), then on a hit a symbol scan of slots 1 .. n-1 for
//  its count n, then the result; one read per cycle.
//  after reset the region table reads as empty at once, no clearing pass.
//  the result shows for one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module address_to_symbol_lookup #(
  parameter int unsigned REGION_COUNT       = 16,
  parameter int unsigned SYMBOLS_PER_REGION = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  atsl_pkg::in_beat_t  in_data,
  output logic                out_valid,
  output atsl_pkg::out_beat_t out_data
);

  localparam int unsigned RW       = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
  localparam int unsigned SW       = $clog2(SYMBOLS_PER_REGION);
  localparam int unsigned AW       = RW + SW;
  localparam int unsigned SY_DEPTH = REGION_COUNT * (1 << SW);
  localparam logic [RW-1:0] R_LAST = RW'(REGION_COUNT - 1);

  atsl_pkg::state_t state_r, state_nxt;

  // region table
  atsl_pkg::region_entry_t rg_mem [REGION_COUNT];
  atsl_pkg::region_entry_t rg_rdata_r;
  atsl_pkg::region_entry_t rg_wdata;
  logic [REGION_COUNT-1:0] rg_vld_r;
  logic                    rg_vld_rd_r;
  logic                    rg_we;
  logic [RW-1:0]           rg_waddr;
  logic [RW-1:0]           rg_raddr;

  // symbol store
  atsl_pkg::sym_entry_t sy_mem [SY_DEPTH];
  atsl_pkg::sym_entry_t sy_rdata_r;
  atsl_pkg::sym_entry_t sy_wdata;
  logic                 sy_we;
  logic [AW-1:0]        sy_waddr;
  logic [AW-1:0]        sy_raddr;

  logic                       accept;
  logic                       rg_load_ok;
  logic                       sy_load_ok;
  logic [atsl_pkg::COUNT_W-1:0] cnt_sat;

  logic [atsl_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic [RW-1:0]               rptr_r, rptr_nxt;
  logic [RW-1:0]               rchk_r, rchk_nxt;
  logic                        r_hit;

  logic                        fobj_r, fobj_nxt;
  logic [RW-1:0]               hidx_r, hidx_nxt;
  logic [atsl_pkg::ADDR_W-1:0] base_r, base_nxt;
  logic [atsl_pkg::ADDR_W-1:0] bias_r, bias_nxt;
  logic [atsl_pkg::COUNT_W-1:0] cnt_r, cnt_nxt;

  logic [atsl_pkg::COUNT_W-1:0] jptr_r, jptr_nxt;
  logic                         issue;
  logic                         v0_r, v0_nxt;
  logic [atsl_pkg::COUNT_W-1:0] j0_r, j0_nxt;
  logic                         v1_r, v1_nxt;
  logic [atsl_pkg::COUNT_W-1:0] j1_r, j1_nxt;
  logic                         ok1_r, ok1_nxt;
  logic [atsl_pkg::ADDR_W-1:0]  sa1_r, sa1_nxt;
  logic [atsl_pkg::ADDR_W-1:0]  sz1_r, sz1_nxt;
  logic [atsl_pkg::ADDR_W-1:0]  s_end;
  logic                         s_take;

  logic                         fsym_r, fsym_nxt;
  logic [atsl_pkg::COUNT_W-1:0] bslot_r, bslot_nxt;
  logic [atsl_pkg::ADDR_W-1:0]  baddr_r, baddr_nxt;

  assign accept = start && !busy;

  assign rg_load_ok = (32'(in_data.region_slot) < REGION_COUNT);
  assign sy_load_ok = rg_load_ok && (32'(in_data.symbol_slot) < SYMBOLS_PER_REGION);
  assign cnt_sat    = (32'(in_data.symbol_total) > SYMBOLS_PER_REGION)
                    ? atsl_pkg::COUNT_W'(SYMBOLS_PER_REGION) : in_data.symbol_total;

  // memory write side, only while idle so no read can overlap
  always_comb begin
    rg_we          = accept && (in_data.action == atsl_pkg::ACT_LOAD_REGION) && rg_load_ok;
    rg_waddr       = RW'(in_data.region_slot);
    rg_wdata.base  = in_data.start_value;
    rg_wdata.fin   = in_data.start_value + in_data.span;
    rg_wdata.bias  = in_data.reloc_bias;
    rg_wdata.count = cnt_sat;
    rg_wdata.live  = in_data.in_use;

    sy_we                  = accept && (in_data.action == atsl_pkg::ACT_LOAD_SYMBOL) && sy_load_ok;
    sy_waddr               = {RW'(in_data.region_slot), SW'(in_data.symbol_slot)};
    sy_wdata.value         = in_data.start_value;
    sy_wdata.size          = in_data.span;
    sy_wdata.flags.defined = in_data.defined;
    sy_wdata.flags.named   = in_data.named;
    sy_wdata.flags.tls     = in_data.thread_local;
  end

  always_ff @(posedge clk) begin
    if (rg_we) begin
      rg_mem[rg_waddr] <= rg_wdata;
    end
    rg_rdata_r <= rg_mem[rg_raddr];
  end

  always_ff @(posedge clk) begin
    if (sy_we) begin
      sy_mem[sy_waddr] <= sy_wdata;
    end
    sy_rdata_r <= sy_mem[sy_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rg_vld_r <= '0;
    end else if (rg_we) begin
      rg_vld_r[rg_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rg_vld_rd_r <= rg_vld_r[rg_raddr];
  end

  assign r_hit = rg_vld_rd_r && rg_rdata_r.live &&
                 (addr_r >= rg_rdata_r.base) && (addr_r < rg_rdata_r.fin);

  assign issue = (state_r == atsl_pkg::ST_SSCAN) && (jptr_r < cnt_r);

  assign s_end  = sa1_r + sz1_r;
  assign s_take = v1_r && ok1_r && (sa1_r <= addr_r) &&
                  ((sz1_r == '0) || (addr_r < s_end)) &&
                  (!fsym_r || (sa1_r > baddr_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      atsl_pkg::ST_IDLE: begin
        if (accept && (in_data.action == atsl_pkg::ACT_QUERY)) begin
          state_nxt = atsl_pkg::ST_RSCAN;
        end
      end
      atsl_pkg::ST_RSCAN: begin
        if (r_hit) begin
          state_nxt = atsl_pkg::ST_SSCAN;
        end else if (rchk_r == R_LAST) begin
          state_nxt = atsl_pkg::ST_DONE;
        end
      end
      atsl_pkg::ST_SSCAN: begin
        if (!issue && !v0_r && !v1_r) begin
          state_nxt = atsl_pkg::ST_DONE;
        end
      end
      atsl_pkg::ST_DONE: begin
        state_nxt = atsl_pkg::ST_IDLE;
      end
      default: state_nxt = atsl_pkg::ST_IDLE;
    endcase
  end

  // datapath and read addresses
  always_comb begin
    addr_nxt  = addr_r;
    rptr_nxt  = rptr_r;
    rchk_nxt  = rchk_r;
    fobj_nxt  = fobj_r;
    hidx_nxt  = hidx_r;
    base_nxt  = base_r;
    bias_nxt  = bias_r;
    cnt_nxt   = cnt_r;
    jptr_nxt  = jptr_r;
    fsym_nxt  = fsym_r;
    bslot_nxt = bslot_r;
    baddr_nxt = baddr_r;
    rg_raddr  = rptr_r;
    sy_raddr  = {hidx_r, SW'(jptr_r)};

    v0_nxt  = issue;
    j0_nxt  = jptr_r;
    v1_nxt  = v0_r;
    j1_nxt  = j0_r;
    ok1_nxt = sy_rdata_r.flags.defined && sy_rdata_r.flags.named && !sy_rdata_r.flags.tls;
    sa1_nxt = bias_r + sy_rdata_r.value;
    sz1_nxt = sy_rdata_r.size;

    unique case (state_r)
      atsl_pkg::ST_IDLE: begin
        rg_raddr = '0;
        if (accept && (in_data.action == atsl_pkg::ACT_QUERY)) begin
          addr_nxt  = in_data.start_value;
          rptr_nxt  = (R_LAST == '0) ? '0 : RW'(1);
          rchk_nxt  = '0;
          fobj_nxt  = 1'b0;
          hidx_nxt  = '0;
          base_nxt  = '0;
          cnt_nxt   = '0;
          jptr_nxt  = atsl_pkg::COUNT_W'(1);
          fsym_nxt  = 1'b0;
          bslot_nxt = '0;
          baddr_nxt = '0;
        end
      end
      atsl_pkg::ST_RSCAN: begin
        rchk_nxt = rptr_r;
        rptr_nxt = (rptr_r == R_LAST) ? rptr_r : rptr_r + 1'b1;
        if (r_hit) begin
          fobj_nxt = 1'b1;
          hidx_nxt = rchk_r;
          base_nxt = rg_rdata_r.base;
          bias_nxt = rg_rdata_r.bias;
          cnt_nxt  = rg_rdata_r.count;
        end
      end
      atsl_pkg::ST_SSCAN: begin
        if (issue) begin
          jptr_nxt = jptr_r + 1'b1;
        end
        if (s_take) begin
          fsym_nxt  = 1'b1;
          bslot_nxt = j1_r;
          baddr_nxt = sa1_r;
        end
      end
      atsl_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= atsl_pkg::ST_IDLE;
      v0_r    <= 1'b0;
      v1_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v0_r    <= v0_nxt;
      v1_r    <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    rptr_r  <= rptr_nxt;
    rchk_r  <= rchk_nxt;
    fobj_r  <= fobj_nxt;
    hidx_r  <= hidx_nxt;
    base_r  <= base_nxt;
    bias_r  <= bias_nxt;
    cnt_r   <= cnt_nxt;
    jptr_r  <= jptr_nxt;
    j0_r    <= j0_nxt;
    j1_r    <= j1_nxt;
    ok1_r   <= ok1_nxt;
    sa1_r   <= sa1_nxt;
    sz1_r   <= sz1_nxt;
    fsym_r  <= fsym_nxt;
    bslot_r <= bslot_nxt;
    baddr_r <= baddr_nxt;
  end

  // outputs
  always_comb begin
    busy      = (state_r != atsl_pkg::ST_IDLE);
    out_valid = (state_r == atsl_pkg::ST_DONE);
    out_data.found_object   = fobj_r;
    out_data.object_index   = 4'(hidx_r);
    out_data.object_base    = base_r;
    out_data.found_symbol   = fsym_r;
    out_data.symbol_index   = 8'(bslot_r);
    out_data.symbol_address = baddr_r;
  end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench of the address to symbol lookup block: a directed
// stimulus table then random load and query traffic, each query result checked field
// by field against a fixed miss beat or a behavioral lookup model kept in the bench
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REGIONS        = 16;
  localparam int unsigned SLOTS          = 256;
  localparam int unsigned RAND_PER_PHASE = 190;
  localparam int unsigned DRAIN_CYCLES   = 300;
  localparam int unsigned LIMIT          = 1_000_000;

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // {in_use, defined, named, thread_local}
  localparam logic [3:0] F_NONE  = 4'b0000;
  localparam logic [3:0] F_LIVE  = 4'b1000;
  localparam logic [3:0] F_SYM   = 4'b0110;
  localparam logic [3:0] F_TLS   = 4'b0111;
  localparam logic [3:0] F_UNDEF = 4'b0010;
  localparam logic [3:0] F_ANON  = 4'b0100;

  localparam logic [63:0] FILL_BASE = 64'h0000_5555_0000_0000;
  localparam logic [3:0][63:0] BASE_POOL = {
    64'hFFFF_FFFF_FFFF_E000, 64'h8000_0000_0000_0000,
    64'h0000_7F00_0000_0000, 64'h0000_0000_0000_0000
  };

  typedef struct {
    atsl_pkg::in_beat_t  beat;
    bit                  typed;
    atsl_pkg::out_beat_t want;
  } row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  atsl_pkg::in_beat_t  in_data;
  logic                out_valid;
  atsl_pkg::out_beat_t out_data;

  logic                 reg_live  [REGIONS];
  logic [63:0]          reg_base  [REGIONS];
  logic [63:0]          reg_size  [REGIONS];
  logic [63:0]          reg_bias  [REGIONS];
  logic [8:0]           reg_count [REGIONS];
  logic [63:0]          sym_value   [REGIONS][SLOTS];
  logic [63:0]          sym_size    [REGIONS][SLOTS];
  atsl_pkg::sym_flags_t sym_flags   [REGIONS][SLOTS];
  bit                   sym_written [REGIONS][SLOTS];

  atsl_pkg::out_beat_t lookup_results[$];
  row_t                directed_rows[$];
  int                  errors = 0;
  int unsigned         cycle_count = 0;

  address_to_symbol_lookup u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic atsl_pkg::out_beat_t lookup_expect(logic [63:0] addr);
    atsl_pkg::out_beat_t res;
    logic [63:0]         fin;
    logic [63:0]         sa;
    logic [63:0]         sym_end;
    int                  hit;
    res = '0;
    hit = -1;
    for (int r = 0; r < REGIONS && hit < 0; r++) begin
      fin = reg_base[r] + reg_size[r];
      if (reg_live[r] && addr >= reg_base[r] && addr < fin) hit = r;
    end
    if (hit < 0) return res;
    res.found_object = 1'b1;
    res.object_index = hit[3:0];
    res.object_base  = reg_base[hit];
    for (int j = 1; j < reg_count[hit]; j++) begin
      sa      = reg_bias[hit] + sym_value[hit][j];
      sym_end = sa + sym_size[hit][j];
      if (sym_flags[hit][j].defined && sym_flags[hit][j].named && !sym_flags[hit][j].tls &&
          sa <= addr && (sym_size[hit][j] == '0 || addr < sym_end) &&
          (!res.found_symbol || sa > res.symbol_address)) begin
        res.found_symbol   = 1'b1;
        res.symbol_index   = j[7:0];
        res.symbol_address = sa;
      end
    end
    return res;
  endfunction

  function automatic bit apply_to_model(atsl_pkg::in_beat_t b,
                                        output atsl_pkg::out_beat_t res);
    int unsigned r;
    int unsigned s;
    res = '0;
    r = 32'(b.region_slot);
    s = 32'(b.symbol_slot);
    case (b.action)
      atsl_pkg::ACT_LOAD_REGION: begin
        reg_base[r]  = b.start_value;
        reg_size[r]  = b.span;
        reg_bias[r]  = b.reloc_bias;
        reg_count[r] = (b.symbol_total > 9'(SLOTS)) ? 9'(SLOTS) : b.symbol_total;
        reg_live[r]  = b.in_use;
        return 1'b0;
      end
      atsl_pkg::ACT_LOAD_SYMBOL: begin
        sym_value[r][s]   = b.start_value;
        sym_size[r][s]    = b.span;
        sym_flags[r][s]   = '{defined: b.defined, named: b.named, tls: b.thread_local};
        sym_written[r][s] = 1'b1;
        return 1'b0;
      end
      atsl_pkg::ACT_QUERY: begin
        res = lookup_expect(b.start_value);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // symbol slots 1 .. n-1 of the region are all loaded
  function automatic int unsigned prefix_len(int unsigned r);
    int unsigned n;
    n = 1;
    while (n < SLOTS && sym_written[r][n]) n++;
    return n;
  endfunction

  function automatic atsl_pkg::in_beat_t mk(logic [1:0] act, logic [3:0] rs, logic [7:0] ss,
                                            logic [63:0] v, logic [63:0] sp, logic [63:0] bi,
                                            logic [8:0] tot, logic [3:0] fl);
    atsl_pkg::in_beat_t b;
    b = '0;
    b.action       = act;
    b.region_slot  = rs;
    b.symbol_slot  = ss;
    b.start_value  = v;
    b.span         = sp;
    b.reloc_bias   = bi;
    b.symbol_total = tot;
    {b.in_use, b.defined, b.named, b.thread_local} = fl;
    return b;
  endfunction

  function automatic atsl_pkg::in_beat_t rand_beat();
    logic [255:0] noise;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return noise[$bits(atsl_pkg::in_beat_t)-1:0];
  endfunction

  function automatic atsl_pkg::in_beat_t gen_region_load();
    atsl_pkg::in_beat_t b;
    int unsigned        lim;
    b = rand_beat();
    b.action = atsl_pkg::ACT_LOAD_REGION;
    b.in_use = ($urandom_range(0, 9) < 8);
    if ($urandom_range(0, 4) != 0)
      b.start_value = BASE_POOL[$urandom_range(0, 3)] + 64'($urandom_range(0, 'h3000));
    case ($urandom_range(0, 5))
      0: ;
      1: b.span = '0;
      default: b.span = 64'($urandom_range(1, 'h2000));
    endcase
    case ($urandom_range(0, 2))
      0: b.reloc_bias = '0;
      1: b.reloc_bias = b.start_value;
      default: ;
    endcase
    if (b.in_use) begin
      lim = prefix_len(32'(b.region_slot));
      if (lim == SLOTS && $urandom_range(0, 1)) b.symbol_total = 9'($urandom_range(SLOTS, 511));
      else b.symbol_total = 9'($urandom_range(0, lim));
    end
    return b;
  endfunction

  function automatic atsl_pkg::in_beat_t gen_symbol_load();
    atsl_pkg::in_beat_t b;
    int unsigned        r;
    int unsigned        pick;
    b = rand_beat();
    b.action = atsl_pkg::ACT_LOAD_SYMBOL;
    r = 32'(b.region_slot);
    if ($urandom_range(0, 9) < 6 && prefix_len(r) < SLOTS) b.symbol_slot = 8'(prefix_len(r));
    pick = $urandom_range(0, 9);
    if (pick < 7) b.start_value = reg_base[r] + 64'($urandom_range(0, 'h1FFF)) - reg_bias[r];
    else if (pick < 8) b.start_value = sym_value[r][$urandom_range(1, SLOTS - 1)];
    pick = $urandom_range(0, 19);
    if (pick < 10) b.span = '0;
    else if (pick < 17) b.span = 64'($urandom_range(1, 'h400));
    if ($urandom_range(0, 3) != 0) begin
      b.defined      = 1'b1;
      b.named        = 1'b1;
      b.thread_local = 1'b0;
    end
    return b;
  endfunction

  function automatic atsl_pkg::in_beat_t gen_query();
    atsl_pkg::in_beat_t b;
    int unsigned        r;
    int unsigned        j;
    logic [63:0]        sa;
    b = rand_beat();
    b.action = atsl_pkg::ACT_QUERY;
    r  = $urandom_range(0, REGIONS - 1);
    j  = $urandom_range(1, SLOTS - 1);
    sa = reg_bias[r] + sym_value[r][j];
    case ($urandom_range(0, 9))
      0: ;
      1: b.start_value = $urandom_range(0, 1) ? '1 : '0;
      2, 3, 4: b.start_value = reg_base[r] + 64'($urandom_range(0, 'h2100)) - 64'h10;
      5: b.start_value = FILL_BASE + 64'($urandom_range(0, 'h10100));
      default: begin
        case ($urandom_range(0, 2))
          0: b.start_value = sa + 64'($urandom_range(0, 'h40)) - 64'd1;
          1: b.start_value = sa + sym_size[r][j];
          default: b.start_value = sa + sym_size[r][j] - 64'd1;
        endcase
      end
    endcase
    return b;
  endfunction

  task automatic issue(atsl_pkg::in_beat_t b, int unsigned idle_pct, bit typed = 1'b0,
                       atsl_pkg::out_beat_t want = '0);
    atsl_pkg::out_beat_t res;
    if ($urandom_range(0, 99) < idle_pct)
      repeat ($urandom_range(1, 6)) begin
        @(negedge clk);
        start <= 1'b0;
      end
    @(negedge clk);
    start   <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (busy);
    if (apply_to_model(b, res)) lookup_results.push_back(typed ? want : res);
  endtask

  task automatic drain_lookups();
    @(negedge clk);
    start <= 1'b0;
    while (lookup_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    atsl_pkg::out_beat_t want;
    if (rst_n && out_valid) begin
      if (lookup_results.size() == 0) begin
        $error("result beat with no query waiting");
        errors++;
      end else begin
        want = lookup_results.pop_front();
        check_field("found_object", 64'(want.found_object), 64'(out_data.found_object));
        check_field("object_index", 64'(want.object_index), 64'(out_data.object_index));
        check_field("object_base", want.object_base, out_data.object_base);
        check_field("found_symbol", 64'(want.found_symbol), 64'(out_data.found_symbol));
        check_field("symbol_index", 64'(want.symbol_index), 64'(out_data.symbol_index));
        check_field("symbol_address", want.symbol_address, out_data.symbol_address);
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    atsl_pkg::in_beat_t b;
    logic [63:0]        fill_bias;
    int unsigned        idle_pct [3];
    int unsigned        pick;
    int unsigned        issued;

    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    idle_pct = '{0, 55, 26};
    for (int r = 0; r < REGIONS; r++) begin
      reg_live[r]  = 1'b0;
      reg_base[r]  = '0;
      reg_size[r]  = '0;
      reg_bias[r]  = '0;
      reg_count[r] = '0;
      for (int s = 0; s < SLOTS; s++) begin
        sym_value[r][s]   = '0;
        sym_size[r][s]    = '0;
        sym_flags[r][s]   = '0;
        sym_written[r][s] = 1'b0;
      end
    end

    directed_rows.push_back('{mk(atsl_pkg::ACT_QUERY, 0, 0, '0, 0, 0, 0, F_NONE), 1'b1, '0});
    directed_rows.push_back('{mk(atsl_pkg::ACT_QUERY, 0, 0, '1, 0, 0, 0, F_NONE), 1'b1, '0});
    directed_rows.push_back('{mk(ACT_UNUSED, '1, '1, '1, '1, '1, '1, '1), 1'b0, '0});
    directed_rows.push_back('{mk(atsl_pkg::ACT_LOAD_SYMBOL, 0, 0, 'h1050, 0, 0, 0, F_SYM),
                              1'b0, '0});
    directed_rows.push_back('{mk(atsl_pkg::ACT_LOAD_SYMBOL, 0, 1, 'h1100, 0, 0, 0, F_SYM),
                              1'b0, '0});
    directed_rows.push_back('{mk(atsl_pkg::ACT_LOAD_SYMBOL, 0, 2, 'h1200, 'h10, 0, 0, F_SYM),
                              1'b0, '0});
    directed_rows.push_back('{mk(atsl_pkg::ACT_LOAD_SYMBOL, 0, 3, 'h1100, 0, 0, 0, F_SYM),
                              1'b0, '0});
    directed_rows.push_back('{mk(atsl_pkg::ACT_LOAD_SYMBOL, 0, 4, 'h1300, 0, 0, 0, F_TLS),
                              1'b0, '0});
    directed_rows.push_back('{mk(atsl_pkg::ACT_LOAD_SYMBOL, 0, 5, 'h1400, 0, 0, 0, F_UNDEF),
                              1'b0, '0});
    directed_rows.push_back('{mk(atsl_pkg::ACT_LOAD_SYMBOL, 0, 6, 'h1500, 0, 0, 0, F_ANON),
                              1'b0, '0});
    directed_rows.push_back('{mk(atsl_pkg::ACT_LOAD_REGION, 0, 0, 'h1000, 'h1000, 0, 7, F_LIVE),
                              1'b0, '0});
    directed_rows.push_back('{mk(atsl_pkg::ACT_QUERY, 0, 0, 'h1060, 0, 0, 0, F_NONE), 1'b0, '0});
    directed_rows.push_back('{mk(atsl_pkg::ACT_QUERY, 0, 0, 'h1150, 0, 0, 0, F_NONE), 1'b0, '0});
    directed_rows.push_back('{mk(atsl_pkg::ACT_QUERY, 0, 0, 'h1205, 0, 0, 0, F_NONE), 1'b0, '0});
    directed_rows.push_back('{mk(atsl_pkg::ACT_QUERY, 0, 0, 'h1210, 0, 0, 0, F_NONE), 1'b0, '0});
    directed_rows.push_back('{mk(atsl_pkg::ACT_QUERY, 0, 0, 'h1FFF, 0, 0, 0, F_NONE), 1'b0, '0});
    directed_rows.push_back('{mk(atsl_pkg::ACT_QUERY, 0, 0, 'h2000, 0, 0, 0, F_NONE), 1'b1, '0});
    directed_rows.push_back('{mk(atsl_pkg::ACT_LOAD_REGION, 1, 0, 64'hFFFF_FFFF_FFFF_FF00,
                                 'h100, 0, 0, F_LIVE), 1'b0, '0});
    directed_rows.push_back('{mk(atsl_pkg::ACT_QUERY, 0, 0, '1, 0, 0, 0, F_NONE), 1'b1, '0});
    directed_rows.push_back('{mk(atsl_pkg::ACT_LOAD_SYMBOL, 2, 1, 'h1020, 0, 0, 0, F_SYM),
                              1'b0, '0});
    directed_rows.push_back('{mk(atsl_pkg::ACT_LOAD_REGION, 2, 0, '0, '1,
                                 64'hFFFF_FFFF_FFFF_F000, 2, F_LIVE), 1'b0, '0});
    directed_rows.push_back('{mk(atsl_pkg::ACT_QUERY, 0, 0, 'h30, 0, 0, 0, F_NONE), 1'b0, '0});
    directed_rows.push_back('{mk(atsl_pkg::ACT_QUERY, 0, 0, 64'hFFFF_FFFF_FFFF_FFFE, 0, 0, 0,
                                 F_NONE), 1'b0, '0});
    directed_rows.push_back('{mk(atsl_pkg::ACT_QUERY, 0, 0, '1, 0, 0, 0, F_NONE), 1'b1, '0});
    directed_rows.push_back('{mk(atsl_pkg::ACT_LOAD_REGION, 0, 0, 'h1000, 'h1000, 0, 9'h1FF,
                                 F_NONE), 1'b0, '0});
    directed_rows.push_back('{mk(atsl_pkg::ACT_QUERY, 0, 0, 'h1150, 0, 0, 0, F_NONE), 1'b0, '0});

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      issue(directed_rows[i].beat, 0, directed_rows[i].typed, directed_rows[i].want);
    drain_lookups();

    for (int p = 0; p < 3; p++) begin
      if (p == 0) begin
        // one region with symbol slots 1 .. SLOTS-1 loaded, for the saturated count
        fill_bias = {$urandom, $urandom};
        for (int j = 1; j < SLOTS; j++) begin
          b = gen_symbol_load();
          b.region_slot = 4'(REGIONS - 1);
          b.symbol_slot = 8'(j);
          b.start_value = FILL_BASE + 64'($urandom_range(0, 'hFFFF)) - fill_bias;
          issue(b, idle_pct[p]);
        end
        b = rand_beat();
        b.action       = atsl_pkg::ACT_LOAD_REGION;
        b.region_slot  = 4'(REGIONS - 1);
        b.start_value  = FILL_BASE;
        b.span         = 64'h10000;
        b.reloc_bias   = fill_bias;
        b.symbol_total = 9'($urandom_range(SLOTS, 511));
        b.in_use       = 1'b1;
        issue(b, idle_pct[p]);
      end
      issued = 0;
      while (issued < RAND_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          b = rand_beat();
          b.action = ACT_UNUSED;
        end else begin
          issued++;
          if (pick < 15) b = gen_region_load();
          else if (pick < 50) b = gen_symbol_load();
          else b = gen_query();
        end
        issue(b, idle_pct[p]);
      end
      drain_lookups();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && lookup_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/atsl_pkg.sv
design/address_to_symbol_lookup.sv
tb/tb.sv
